// ===== hw/rtl/sliding_window_first_negative_macros.svh =====
// ----------------------------------------------------------------------------
// sliding window first negative: assertion macros
// shared assertion forms, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_FIRST_NEGATIVE_MACROS_SVH
`define SLIDING_WINDOW_FIRST_NEGATIVE_MACROS_SVH

// same-cycle implication
`define SWFN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWFN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/swfn_pkg.sv =====
// ----------------------------------------------------------------------------
// swfn_pkg
// shared constants and types of the sliding window first negative block
// ----------------------------------------------------------------------------
`default_nettype none

package swfn_pkg;

	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 11;

	localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(1);

	// per-word control handed from the top level to the queue
	typedef struct packed {
		logic take;
		logic clear;
		logic push;
	} swfn_step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swfn_if.sv =====
// ----------------------------------------------------------------------------
// swfn stream interfaces
// valid/ready channels for samples and for results
// ----------------------------------------------------------------------------
`default_nettype none

interface swfn_in_if #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_array;

	modport source (output valid, output sample, output start_of_array, input ready);
	modport sink   (input valid, input sample, input start_of_array, output ready);
endinterface

interface swfn_out_if #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] first_negative;

	modport source (output valid, output first_negative, input ready);
	modport sink   (input valid, input first_negative, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swfn_ram.sv =====
// ----------------------------------------------------------------------------
// swfn_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module swfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/swfn_queue.sv =====
// ----------------------------------------------------------------------------
// swfn_queue
// fifo of negative samples with positions; ram store plus a two-entry
// front cache so expiry, push and head read all fit in the same cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_first_negative_macros.svh"

module swfn_queue #(
	parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire swfn_pkg::swfn_step_t                   step,
	input  wire logic signed [SAMPLE_BITS-1:0]          sample,
	input  wire logic [$clog2(2*WINDOW_MAX)-1:0]        pos,
	input  wire logic [$clog2(WINDOW_MAX+1)-1:0]        win,
	output logic                                        front_valid,
	output logic signed [SAMPLE_BITS-1:0]               front_value
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int PW = $clog2(2 * WINDOW_MAX);
	localparam int EW = SAMPLE_BITS + PW;
	localparam logic [PW:0]   POS_MOD = (PW + 1)'(2 * WINDOW_MAX);
	localparam logic [CW-1:0] CNT_MAX = CW'(WINDOW_MAX);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		if (p == AW'(WINDOW_MAX - 1)) begin
			return '0;
		end
		return p + AW'(1);
	endfunction

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [EW-1:0] e0_q, e1_q;  // entries at head and head+1, {value, position}
	logic          e1_pend_q;   // head+1 entry is arriving on the ram read port

	logic [AW-1:0] hd, tl, hd_n, tl_n;
	logic [CW-1:0] cnt, cnt1, cnt_n;
	logic [EW-1:0] e1_eff, front_e, new_e, e0_n, e1_n, rdata;
	logic [PW-1:0] e0_pos, age;
	logic [PW:0]   age_w;
	logic          expire, push, rd_en, wr_en;

	always_comb begin
		hd      = step.clear ? '0 : head_q;
		tl      = step.clear ? '0 : tail_q;
		cnt     = step.clear ? '0 : count_q;
		e1_eff  = e1_pend_q ? rdata : e1_q;
		e0_pos  = e0_q[PW-1:0];
		new_e   = {sample, pos};

		// age modulo the position range
		if (pos >= e0_pos) begin
			age_w = {1'b0, pos} - {1'b0, e0_pos};
		end else begin
			age_w = {1'b0, pos} + POS_MOD - {1'b0, e0_pos};
		end
		age = age_w[PW-1:0];

		expire  = (cnt != '0) && (age >= PW'(win));
		cnt1    = cnt - CW'(expire);
		push    = step.push && (cnt1 != CNT_MAX);
		cnt_n   = cnt1 + CW'(push);
		hd_n    = expire ? ring_next(hd) : hd;
		tl_n    = push ? ring_next(tl) : tl;
		front_e = expire ? e1_eff : e0_q;

		front_valid = (cnt1 != '0) || push;
		front_value = (cnt1 != '0) ? front_e[EW-1:PW] : sample;

		e0_n  = (cnt1 != '0) ? front_e : new_e;
		// after an expiry with two or more left, head+1 comes from the ram
		e1_n  = (!expire && cnt1 > CW'(1)) ? e1_eff : new_e;
		rd_en = step.take && expire && (cnt1 > CW'(1));
		wr_en = step.take && push;
	end

	swfn_ram #(
		.WIDTH(EW),
		.DEPTH(WINDOW_MAX)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(tl),
		.wdata(new_e),
		.re   (rd_en),
		.raddr(ring_next(hd_n)),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			e1_pend_q <= 1'b0;
		end else if (step.take) begin
			head_q    <= hd_n;
			tail_q    <= tl_n;
			count_q   <= cnt_n;
			e1_pend_q <= rd_en;
		end else begin
			e1_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.take) begin
			e0_q <= e0_n;
			e1_q <= e1_n;
		end else if (e1_pend_q) begin
			e1_q <= rdata;
		end
	end

	`SWFN_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_MAX, "queue count above capacity")
	`SWFN_ASSERT_NOW(a_no_rw_clash, wr_en && rd_en, tl != ring_next(hd_n),
		"ram read and write hit the same entry")
	`SWFN_ASSERT_NEXT(a_fetch_pending, rd_en, e1_pend_q, "head+1 fetch not tracked")

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_first_negative.sv =====
// ----------------------------------------------------------------------------
// sliding_window_first_negative
// first negative sample in each sliding window of a sample stream
// ----------------------------------------------------------------------------
// usage:
//   stream carries signed samples; start_of_array on a word makes it element
//   zero of a new array. result carries one word per sample once window_size
//   samples of the current array have arrived: the first negative sample of
//   the window ending at that sample, or zero when there is none.
//   cfg_we/cfg_wdata write window_size (0 acts as 1, above WINDOW_MAX acts
//   as WINDOW_MAX); write it only while the block is idle.
// timing:
//   one word accepted per cycle while stream.ready is high, result in the
//   cycle after acceptance. the queue ram is read at most once per word
//   (head+1 prefetch), written at most once; the front pair sits in registers.
// reset:
//   arst_n clears the queue, counters and result valid flag; window_size
//   returns to 1. stored queue entries are not cleared.
// stall:
//   the result register holds while result.ready is low; stream.ready drops
//   only while a held result is not taken in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_first_negative_macros.svh"

module sliding_window_first_negative #(
	parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	swfn_in_if.sink                            stream,
	swfn_out_if.source                         result,
	input  wire logic                          cfg_we,
	input  wire logic [swfn_pkg::CFG_BITS-1:0] cfg_wdata
);

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int PW = $clog2(2 * WINDOW_MAX);
	localparam int WW = (CW > swfn_pkg::CFG_BITS) ? CW : swfn_pkg::CFG_BITS;
	localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_MAX - 1);

	logic [swfn_pkg::CFG_BITS-1:0] win_q;
	logic [PW-1:0]                 pos_q, pos_c, pos_n;
	logic [CW-1:0]                 seen_q, seen_c, seen_a, seen_n, w;
	logic [WW-1:0]                 ws;
	logic                          take, emit, front_valid, out_valid_q;
	logic signed [SAMPLE_BITS-1:0] front_value, out_data_q;
	swfn_pkg::swfn_step_t          step;

	assign stream.ready          = !out_valid_q || result.ready;
	assign take                  = stream.valid && stream.ready;
	assign result.valid          = out_valid_q;
	assign result.first_negative = out_data_q;

	always_comb begin
		ws = WW'(win_q);
		if (ws == '0) begin
			w = CW'(1);
		end else if (ws > WW'(WINDOW_MAX)) begin
			w = CW'(WINDOW_MAX);
		end else begin
			w = CW'(ws);
		end

		pos_c  = stream.start_of_array ? '0 : pos_q;
		pos_n  = (pos_c == POS_LAST) ? '0 : pos_c + PW'(1);
		seen_c = stream.start_of_array ? '0 : seen_q;
		seen_a = (seen_c > w) ? w : seen_c;  // clamp after a window shrink
		seen_n = (seen_a < w) ? seen_a + CW'(1) : seen_a;
		emit   = (seen_n >= w);

		step.take  = take;
		step.clear = stream.start_of_array;
		step.push  = stream.sample[SAMPLE_BITS-1];
	end

	swfn_queue #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.sample     (stream.sample),
		.pos        (pos_c),
		.win        (w),
		.front_valid(front_valid),
		.front_value(front_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= swfn_pkg::WINDOW_RESET;
			pos_q       <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (take) begin
				pos_q       <= pos_n;
				seen_q      <= seen_n;
				out_valid_q <= emit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_data_q <= front_valid ? front_value : '0;
		end
	end

	`SWFN_ASSERT_NEXT(a_start_pos, take && stream.start_of_array, pos_q == PW'(1),
		"position not restarted by start of array")
	`SWFN_ASSERT_NEXT(a_start_seen, take && stream.start_of_array, seen_q == CW'(1),
		"sample count not restarted by start of array")

endmodule

`default_nettype wire
